FILE: rtl/core/transaction_write_set_log_unit_defines.svh
// ----------------------------------------------------------------------------
// transaction write-set log: assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef TRANSACTION_WRITE_SET_LOG_UNIT_DEFINES_SVH
`define TRANSACTION_WRITE_SET_LOG_UNIT_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define TWSL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TWSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/twsl_pkg.sv
// ----------------------------------------------------------------------------
// twsl_pkg
// shared sizes, codes and types of the transaction write-set log
// ----------------------------------------------------------------------------
package twsl_pkg;

  localparam int LOG_DEPTH     = 4096;
  localparam int ADDR_W        = $clog2(LOG_DEPTH);
  localparam int CNT_W         = $clog2(LOG_DEPTH + 1);
  localparam int ENTRY_COUNT_W = 13;

  // opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // record kinds
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // one stored record
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] row_slot;
    logic [7:0]  node_num;
    logic [7:0]  table_num;
    logic [31:0] tuple_num;
    logic [31:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result
  typedef struct packed {
    logic [2:0]       status;
    logic [31:0]      found_value;
    logic [CNT_W-1:0] count;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/twsl_ram.sv
// ----------------------------------------------------------------------------
// twsl_ram
// simple dual-port synchronous memory, one write and one registered read port
// ----------------------------------------------------------------------------
module twsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/twsl_ctrl.sv
// ----------------------------------------------------------------------------
// twsl_ctrl
// transaction sequencer: append, clear and newest-first lookup scan
// ----------------------------------------------------------------------------
`include "transaction_write_set_log_unit_defines.svh"

module twsl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  twsl_pkg::entry_t            in_item,
  output logic                        res_valid,
  input  logic                        res_take,
  output twsl_pkg::res_t              res,
  output logic                        wr_en,
  output logic [twsl_pkg::ADDR_W-1:0] wr_addr,
  output twsl_pkg::entry_t            wr_data,
  output logic                        rd_en,
  output logic [twsl_pkg::ADDR_W-1:0] rd_addr,
  input  twsl_pkg::entry_t            rd_data
);

  import twsl_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [7:0]        key_table_r, key_table_nxt;
  logic [31:0]       key_tuple_r, key_tuple_nxt;
  logic              issue_r, issue_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  res_t              res_r, res_nxt;

  logic fire;
  logic full;
  logic hit;

  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_DONE) && res_take);
  assign fire      = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(LOG_DEPTH));
  assign hit       = pend_r && (rd_data.table_num == key_table_r)
                     && (rd_data.tuple_num == key_tuple_r);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    key_table_r <= key_table_nxt;
    key_tuple_r <= key_tuple_nxt;
    pend_last_r <= pend_last_nxt;
    res_r       <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    key_table_nxt = key_table_r;
    key_tuple_nxt = key_tuple_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[ADDR_W-1:0];
    wr_data       = in_item;
    rd_en         = 1'b0;
    rd_addr       = idx_r;

    case (state_r)
      S_IDLE: begin
      end
      S_SCAN: begin
        // issue the next older entry while checking the one read last cycle
        if (issue_r) begin
          rd_en         = 1'b1;
          pend_nxt      = 1'b1;
          pend_last_nxt = (idx_r == '0);
          idx_nxt       = idx_r - 1'b1;
          if (idx_r == '0) begin
            issue_nxt = 1'b0;
          end
        end
        if (hit) begin
          res_nxt.count = count_r;
          if (rd_data.kind == KIND_DELETE) begin
            res_nxt.status      = ST_DELETED;
            res_nxt.found_value = '0;
          end else begin
            res_nxt.status      = ST_FOUND;
            res_nxt.found_value = rd_data.value;
          end
          state_nxt = S_DONE;
        end else if (pend_r && pend_last_r) begin
          res_nxt.status      = ST_NOTFOUND;
          res_nxt.found_value = '0;
          res_nxt.count       = count_r;
          state_nxt           = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fire) begin
      res_nxt.status      = ST_OK;
      res_nxt.found_value = '0;
      state_nxt           = S_DONE;
      case (in_op)
        OP_APPEND: begin
          if (full) begin
            res_nxt.status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_LOOKUP: begin
          key_table_nxt = in_item.table_num;
          key_tuple_nxt = in_item.tuple_num;
          if (count_r == '0) begin
            res_nxt.status = ST_NOTFOUND;
          end else begin
            idx_nxt   = ADDR_W'(count_r - 1'b1);
            issue_nxt = 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
      res_nxt.count = count_nxt;
    end
  end

  `TWSL_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(LOG_DEPTH), "record count beyond depth")
  `TWSL_ASSERT_SAME(a_no_write_in_scan, state_r == S_SCAN, !wr_en, "write during lookup scan")
  `TWSL_ASSERT_NEXT(a_append_grows, fire && (in_op == OP_APPEND) && !full, count_r == $past(count_r) + 1'b1, "append did not grow log")
  `TWSL_ASSERT_NEXT(a_empty_lookup, fire && (in_op == OP_LOOKUP) && (count_r == '0), (state_r == S_DONE) && (res_r.status == ST_NOTFOUND), "empty lookup not answered")

endmodule

FILE: rtl/core/transaction_write_set_log_unit.sv
// ----------------------------------------------------------------------------
// transaction_write_set_log_unit
// write-set log of one transaction: append, newest-first lookup and clear
// ----------------------------------------------------------------------------
// usage
//   input channel in_*: one transaction per item, opcode in in_tuser
//   (append, lookup, clear), record fields in in_tdata
//   result channel out_*: exactly one result per input transaction, status in
//   out_tuser, found value and record count after the item in out_tdata
// result timing
//   append, clear and unused opcodes: result registered in the sequencer and
//   then in the output register; a new transaction can be taken as it moves
//   on. lookup over n stored records (n up to 4096): the single read port of
//   the record memory reads one entry a cycle from the newest back, stopping
//   at the first match or the oldest entry; that result then goes the same way
// reset
//   rst_n clears the record count and all handshake state; the record
//   memory is not cleared and needs no clearing pass
// back-pressure
//   a finished result waits in the output register while the next
//   transaction is taken and worked; a second result then waits in the
//   sequencer, which takes no new transaction until it is passed on
// ----------------------------------------------------------------------------
module transaction_write_set_log_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // record_kind[1:0], table_number[9:2], tuple_number[41:10],
  // row_slot[73:42], tuple_value[105:74], node_number[113:106], zero fill
  input  logic [119:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // found_value[31:0], entry_count[44:32], zero fill
  output logic [47:0]  out_tdata,
  // status[2:0]
  output logic [2:0]   out_tuser
);

  import twsl_pkg::*;

  entry_t            in_item;
  logic              res_valid;
  logic              res_take;
  res_t              res;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_word;
  entry_t            rd_data;

  // output register
  logic out_valid_r;
  res_t out_res_r;

  // unpack the incoming record
  always_comb begin
    in_item.kind      = in_tdata[1:0];
    in_item.table_num = in_tdata[9:2];
    in_item.tuple_num = in_tdata[41:10];
    in_item.row_slot  = in_tdata[73:42];
    in_item.value     = in_tdata[105:74];
    in_item.node_num  = in_tdata[113:106];
  end

  assign rd_data = entry_t'(rd_word);

  // record store: one write per append, one read per scan step
  twsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LOG_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(wr_data)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // sequencer for append, clear and lookup
  twsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // result moves on when the output register is empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid        = out_valid_r;
  assign out_tdata[31:0]   = out_res_r.found_value;
  assign out_tdata[44:32]  = ENTRY_COUNT_W'(out_res_r.count);
  assign out_tdata[47:45]  = '0;
  assign out_tuser         = out_res_r.status;

endmodule
